### design/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    // Headroom above the operand width in the shift-add datapath: 2r + x < 3n
    localparam int unsigned GUARD_W = 2;

endpackage

### design/modexp_mulmod.sv
`timescale 1ns / 1ps

// Bit-serial modular multiplier: r = x * y mod n, one bit of y per cycle, MSB first.
// Requires x < n (or x = 1 with n >= 1) and n != 0.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int unsigned MOD_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] op_x,
    input  logic [MOD_WIDTH-1:0] op_y,
    input  logic [MOD_WIDTH-1:0] op_n,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] result
);

    localparam int unsigned CW = $clog2(MOD_WIDTH);
    localparam int unsigned TW = MOD_WIDTH + GUARD_W;
    localparam logic [CW-1:0] LAST_BIT = CW'(MOD_WIDTH - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [MOD_WIDTH-1:0] x_reg;
    logic [MOD_WIDTH-1:0] y_reg;
    logic [MOD_WIDTH-1:0] n_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] acc_next;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] n1_ext;
    logic [TW-1:0] n2_ext;

    // Shift-add step with conditional subtraction of n or 2n
    always_comb begin
        n1_ext = {{GUARD_W{1'b0}}, n_reg};
        n2_ext = {1'b0, n_reg, 1'b0};
        t_sum  = {1'b0, acc_reg, 1'b0}
               + (y_reg[MOD_WIDTH-1] ? {{GUARD_W{1'b0}}, x_reg} : '0);
        if (t_sum >= n2_ext) begin
            acc_next = MOD_WIDTH'(t_sum - n2_ext);
        end else if (t_sum >= n1_ext) begin
            acc_next = MOD_WIDTH'(t_sum - n1_ext);
        end else begin
            acc_next = t_sum[MOD_WIDTH-1:0];
        end
    end

    // Control: count the multiplier bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_BIT;
            end
        end
    end

    // Datapath: latch operands, then advance one bit per cycle
    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            x_reg   <= op_x;
            y_reg   <= op_y;
            n_reg   <= op_n;
            acc_reg <= '0;
        end else if (busy_reg) begin
            y_reg   <= {y_reg[MOD_WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### design/modular_exponentiation_unit.sv
`timescale 1ns / 1ps

// Modular exponentiation: cipher = message ^ exponent mod modulus.
// Input stream s_*: one message per transfer. Output stream m_*: one cipher per
// message, in order. Modulus and exponent are written through cfg_wr_* (index 0
// modulus, index 1 exponent, other indexes ignored); the user writes them only
// while no item is in flight, and the block itself does not enforce this. One
// item is worked at a time: s_tready is high only while the sequencer idles.
// The base is first reduced mod n, then square-and-multiply runs over all
// MOD_WIDTH exponent bits, MSB first. Every modular product goes through one
// shared bit-serial multiplier. A modulus of zero skips both and gives 0.
// The result sits in an output register; the next message is taken while it
// waits, and a finished item waits in the sequencer while that register is
// full and m_tready stays low.
// Reset (aresetn, synchronous, active low) sets modulus and exponent to 1,
// drops any item in flight and clears m_tvalid.
module modular_exponentiation_unit import modexp_pkg::*; #(
    parameter int unsigned MOD_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_wr_idx,
    input  logic [MOD_WIDTH-1:0]        cfg_wr_data,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((MOD_WIDTH+7)/8)*8-1:0] s_tdata,   // message
    // Output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((MOD_WIDTH+7)/8)*8-1:0] m_tdata    // cipher
);

    localparam int unsigned DW = ((MOD_WIDTH + 7) / 8) * 8;
    localparam int unsigned CW = $clog2(MOD_WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(MOD_WIDTH - 1);
    localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BASE = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] exponent_reg;
    logic [MOD_WIDTH-1:0] n_reg;
    logic [MOD_WIDTH-1:0] exp_reg, exp_next;
    logic [MOD_WIDTH-1:0] base_reg, base_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [CW-1:0]        bit_reg, bit_next;
    logic                 m_valid_reg;
    logic [MOD_WIDTH-1:0] m_data_reg;

    logic                 mm_start;
    logic [MOD_WIDTH-1:0] mm_x;
    logic [MOD_WIDTH-1:0] mm_y;
    logic                 mm_done;
    logic [MOD_WIDTH-1:0] mm_result;
    logic                 s_fire;
    logic                 out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= ONE;
            exponent_reg <= ONE;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                REG_MODULUS:  modulus_reg  <= cfg_wr_data;
                REG_EXPONENT: exponent_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer: base reduction, then square and optional multiply per exponent bit
    always_comb begin
        state_next = state_reg;
        exp_next   = exp_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        bit_next   = bit_reg;
        mm_start   = 1'b0;
        mm_x       = mm_result;
        mm_y       = mm_result;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    exp_next = exponent_reg;
                    bit_next = LAST_BIT;
                    if (modulus_reg == '0) begin
                        acc_next   = '0;
                        state_next = S_OUT;
                    end else begin
                        acc_next   = (modulus_reg == ONE) ? '0 : ONE;
                        mm_start   = 1'b1;
                        mm_x       = ONE;
                        mm_y       = s_tdata[MOD_WIDTH-1:0];
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE: begin
                if (mm_done) begin
                    base_next  = mm_result;
                    mm_start   = 1'b1;
                    mm_x       = acc_reg;
                    mm_y       = acc_reg;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    acc_next = mm_result;
                    if (exp_reg[MOD_WIDTH-1]) begin
                        mm_start   = 1'b1;
                        mm_y       = base_reg;
                        state_next = S_MUL;
                    end else if (bit_reg == '0) begin
                        state_next = S_OUT;
                    end else begin
                        exp_next = {exp_reg[MOD_WIDTH-2:0], 1'b0};
                        bit_next = bit_reg - 1'b1;
                        mm_start = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    acc_next = mm_result;
                    if (bit_reg == '0) begin
                        state_next = S_OUT;
                    end else begin
                        exp_next   = {exp_reg[MOD_WIDTH-2:0], 1'b0};
                        bit_next   = bit_reg - 1'b1;
                        mm_start   = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the sequencer state and working values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            n_reg <= modulus_reg;
        end
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
    end

    // Output register: load a finished result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= acc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'(m_data_reg);

    modexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_x    (mm_x),
        .op_y    (mm_y),
        .op_n    ((state_reg == S_IDLE) ? modulus_reg : n_reg),
        .done    (mm_done),
        .result  (mm_result)
    );

endmodule
